// ===== sv/dual_pedal_sensor_plausibility_unit_assert.svh =====
// Assertion macros for the dual pedal sensor plausibility unit.
// Expects aclk and aresetn in the scope of the module that uses them.
`ifndef DUAL_PEDAL_SENSOR_PLAUSIBILITY_UNIT_ASSERT_SVH
`define DUAL_PEDAL_SENSOR_PLAUSIBILITY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DPSP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dpsp assertion failed");

// Next-cycle implication.
`define DPSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dpsp assertion failed");

`endif

// ===== sv/dpsp_pkg.sv =====
// Shared types, constants and the exponent root table of the pedal plausibility unit.
// No dependencies.
`timescale 1ns / 1ps

package dpsp_pkg;

    localparam int SENS_W  = 12;
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = FRAC_W + 1;
    localparam int DVD_W   = SENS_W + FRAC_W;
    localparam int EXP_W   = 15;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ADDR_W  = 3;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_S1_HIGH = 3'd1;
    localparam logic [2:0] STAT_S1_LOW  = 3'd2;
    localparam logic [2:0] STAT_S2_HIGH = 3'd3;
    localparam logic [2:0] STAT_S2_LOW  = 3'd4;
    localparam logic [2:0] STAT_IMPL    = 3'd5;

    localparam logic REQ_CAL = 1'b1;

    localparam logic [ADDR_W-1:0] REG_S1_MIN = 3'd0;
    localparam logic [ADDR_W-1:0] REG_S1_MAX = 3'd1;
    localparam logic [ADDR_W-1:0] REG_S2_MIN = 3'd2;
    localparam logic [ADDR_W-1:0] REG_S2_MAX = 3'd3;
    localparam logic [ADDR_W-1:0] REG_EXP    = 3'd4;

    localparam logic [EXP_W-1:0] EXP_MIN   = 15'd8193;
    localparam logic [EXP_W-1:0] EXP_RESET = 15'd16384;

    typedef logic [15:0][31:0] ttab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bv;
        logic [63:0] rem;
        r   = '0;
        bv  = 64'h4000_0000_0000_0000;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + bv) begin
                rem = rem - (r + bv);
                r   = (r >> 1) + bv;
            end else begin
                r   = r >> 1;
            end
            bv = bv >> 2;
        end
        return r;
    endfunction

    // Entry k holds 2^32 * 2^-(2^-(k+1)), rounded down by repeated roots.
    function automatic ttab_t build_ttab();
        ttab_t       t;
        logic [63:0] cur;
        cur = isqrt64(64'h8000_0000_0000_0000);
        for (int k = 0; k < 16; k++) begin
            t[k] = cur[31:0];
            cur  = isqrt64({cur[31:0], 32'h0});
        end
        return t;
    endfunction

    localparam ttab_t T_TAB = build_ttab();

endpackage

// ===== sv/dual_pedal_sensor_plausibility_unit.sv =====
// Dual pedal sensor plausibility unit: sequencer, bounds, fault latch and output beat.
// Depends on dpsp_pkg, dpsp_div, dpsp_mul and the assertion macro header.
//
// Usage: one input beat carries a sensor sample pair with a millisecond stamp
// (tuser low) or a calibration start request (tuser high). Each input beat gives
// exactly one output beat with the shaped pedal value and a status code.
// Configuration writes go through cfg_we/cfg_addr/cfg_wdata; the user must write only
// while the unit is idle, which the block itself does not enforce; writing a
// start bound also loads that sensor's working bound. Calibration, window, latched
// and bound fault answers go from ST_CHECK straight to ST_DONE; implausible, zero and
// full-scale answers first pass through both divisions and ST_PLAUS. A shaped value
// takes two serial divisions, normalize shifts, 16 squarings plus 2 to 18 further
// products on the serial multiplier, and one ST_EXPK step per exponent bit. One item
// is worked on at a time; s_axis_tready is high while the sequencer is idle.
// A finished result sits in the output register; a new item is taken while it
// waits, and the next result holds until the receiver takes the first.
// Reset: bounds go to 0 / 4095, exponent to 1.0, window and fault latch clear,
// no clearing pass. A latched fault holds until reset.
`timescale 1ns / 1ps
`include "dual_pedal_sensor_plausibility_unit_assert.svh"

module dual_pedal_sensor_plausibility_unit #(
    parameter int ADC_BITS      = 12,
    parameter int CAL_WINDOW_MS = 5000
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sensor_one[11:0], sensor_two[23:12], time_ms[55:24]
    input  logic [55:0]                   s_axis_tdata,
    // req_type[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pedal_value[8:0], status[11:9], zero[15:12]
    output logic [15:0]                   m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [dpsp_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [dpsp_pkg::EXP_W-1:0]    cfg_wdata
);
    import dpsp_pkg::*;

    localparam logic [SENS_W-1:0] ADC_MASK = SENS_W'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [31:0]       CAL_LEN  = 32'(CAL_WINDOW_MS);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_CHECK  = 12'b0000_0000_0010,
        ST_DIV1   = 12'b0000_0000_0100,
        ST_DIV2   = 12'b0000_0000_1000,
        ST_PLAUS  = 12'b0000_0001_0000,
        ST_NORM   = 12'b0000_0010_0000,
        ST_LOGSQ  = 12'b0000_0100_0000,
        ST_PMUL   = 12'b0000_1000_0000,
        ST_EXPK   = 12'b0001_0000_0000,
        ST_EXPMUL = 12'b0010_0000_0000,
        ST_FMUL   = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SENS_W-1:0]  lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [31:0]        win_reg;
    logic [2:0]         latched_reg;

    logic               req_reg;
    logic [SENS_W-1:0]  x1_reg, x2_reg;
    logic [31:0]        now_reg;
    logic [RATIO_W-1:0] r1_reg, r2_reg;
    logic [15:0]        m_reg;
    logic [3:0]         e_reg;
    logic [15:0]        fr_reg;
    logic [3:0]         kcnt_reg;
    logic [15:0]        f_reg;
    logic [4:0]         ip_reg;
    logic [32:0]        r_reg;
    logic [4:0]         ecnt_reg;
    logic [8:0]         res_val_reg;
    logic [2:0]         res_st_reg;

    logic               m_val_reg;
    logic [8:0]         m_pedal_reg;
    logic [2:0]         m_stat_reg;

    logic               out_free;
    logic               in_window;
    logic [2:0]         flt_st;
    logic [SENS_W-1:0]  span1, span2, num1, num2;
    logic               div_start, div_done;
    logic [SENS_W-1:0]  div_num, div_den;
    logic [RATIO_W-1:0] div_q;
    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic [RATIO_W-1:0] diff;
    logic [20:0]        diff10;
    logic [RATIO_W:0]   avg_sum;
    logic [RATIO_W-1:0] avg;
    logic [16:0]        sq;
    logic [15:0]        m_new;
    logic [15:0]        fr_new;
    logic [20:0]        n_val;
    logic               mul_st;
    logic               div_st;

    assign out_free  = !m_val_reg || m_axis_tready;
    assign in_window = now_reg < win_reg;
    assign span1     = hi1_reg - lo1_reg;
    assign span2     = hi2_reg - lo2_reg;
    assign num1      = x1_reg - lo1_reg;
    assign num2      = x2_reg - lo2_reg;

    always_comb begin
        if (x1_reg > hi1_reg) begin
            flt_st = STAT_S1_HIGH;
        end else if (x1_reg < lo1_reg) begin
            flt_st = STAT_S1_LOW;
        end else if (x2_reg > hi2_reg) begin
            flt_st = STAT_S2_HIGH;
        end else if (x2_reg < lo2_reg) begin
            flt_st = STAT_S2_LOW;
        end else begin
            flt_st = STAT_OK;
        end
    end

    assign diff    = (r1_reg > r2_reg) ? (r1_reg - r2_reg) : (r2_reg - r1_reg);
    assign diff10  = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
    assign avg_sum = {1'b0, r1_reg} + {1'b0, r2_reg};
    assign avg     = avg_sum[RATIO_W:1];

    assign sq     = mul_prod[31:15];
    assign m_new  = sq[16] ? sq[16:1] : sq[15:0];
    assign fr_new = {fr_reg[14:0], sq[16]};
    assign n_val  = {({1'b0, e_reg} + 5'd1), 16'h0} - {5'd0, fr_new};

    assign div_num = (state_reg == ST_CHECK) ? num1 : num2;
    assign div_den = (state_reg == ST_CHECK) ? span1 : span2;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (latched_reg != STAT_OK || req_reg == REQ_CAL || in_window
                        || flt_st != STAT_OK) begin
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) state_next = ST_PLAUS;
            end
            ST_PLAUS: begin
                if (diff10 > 21'd65536 || avg == '0 || avg[RATIO_W-1]) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (m_reg[15]) begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(m_reg);
                    mul_b      = MUL_B_W'(m_reg);
                    state_next = ST_LOGSQ;
                end
            end
            ST_LOGSQ: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    if (kcnt_reg == 4'd15) begin
                        mul_a      = MUL_A_W'(n_val);
                        mul_b      = MUL_B_W'(exp_reg);
                        state_next = ST_PMUL;
                    end else begin
                        mul_a = MUL_A_W'(m_new);
                        mul_b = MUL_B_W'(m_new);
                    end
                end
            end
            ST_PMUL: begin
                if (mul_done) state_next = ST_EXPK;
            end
            ST_EXPK: begin
                if (ecnt_reg[4]) begin
                    mul_start  = 1'b1;
                    mul_a      = r_reg >> ip_reg;
                    mul_b      = MUL_B_W'(500);
                    state_next = ST_FMUL;
                end else if (f_reg[15]) begin
                    mul_start  = 1'b1;
                    mul_a      = r_reg;
                    mul_b      = T_TAB[ecnt_reg[3:0]];
                    state_next = ST_EXPMUL;
                end
            end
            ST_EXPMUL: begin
                if (mul_done) state_next = ST_EXPK;
            end
            ST_FMUL: begin
                if (mul_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lo1_reg     <= '0;
            hi1_reg     <= '1;
            lo2_reg     <= '0;
            hi2_reg     <= '1;
            exp_reg     <= EXP_RESET;
            win_reg     <= '0;
            latched_reg <= STAT_OK;
            m_val_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_DONE && out_free) begin
                m_val_reg   <= 1'b1;
                m_pedal_reg <= res_val_reg;
                m_stat_reg  <= res_st_reg;
            end else if (m_axis_tready) begin
                m_val_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_addr)
                    REG_S1_MIN: lo1_reg <= cfg_wdata[SENS_W-1:0];
                    REG_S1_MAX: hi1_reg <= cfg_wdata[SENS_W-1:0];
                    REG_S2_MIN: lo2_reg <= cfg_wdata[SENS_W-1:0];
                    REG_S2_MAX: hi2_reg <= cfg_wdata[SENS_W-1:0];
                    REG_EXP: begin
                        if (cfg_wdata >= EXP_MIN) exp_reg <= cfg_wdata;
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        req_reg <= s_axis_tuser;
                        x1_reg  <= s_axis_tdata[11:0] & ADC_MASK;
                        x2_reg  <= s_axis_tdata[23:12] & ADC_MASK;
                        now_reg <= s_axis_tdata[55:24];
                    end
                end
                ST_CHECK: begin
                    res_val_reg <= '0;
                    if (latched_reg != STAT_OK) begin
                        res_st_reg <= latched_reg;
                    end else if (req_reg == REQ_CAL) begin
                        res_st_reg <= STAT_OK;
                        win_reg    <= now_reg + CAL_LEN;
                    end else if (in_window) begin
                        res_st_reg <= STAT_OK;
                        if (x1_reg < lo1_reg) begin
                            lo1_reg <= x1_reg;
                        end else if (x1_reg > hi1_reg) begin
                            hi1_reg <= x1_reg;
                        end
                        if (x2_reg < lo2_reg) begin
                            lo2_reg <= x2_reg;
                        end else if (x2_reg > hi2_reg) begin
                            hi2_reg <= x2_reg;
                        end
                    end else begin
                        res_st_reg <= flt_st;
                        if (flt_st != STAT_OK) latched_reg <= flt_st;
                    end
                end
                ST_DIV1: begin
                    if (div_done) r1_reg <= (span1 == '0) ? '0 : div_q;
                end
                ST_DIV2: begin
                    if (div_done) r2_reg <= (span2 == '0) ? '0 : div_q;
                end
                ST_PLAUS: begin
                    if (diff10 > 21'd65536) begin
                        latched_reg <= STAT_IMPL;
                        res_st_reg  <= STAT_IMPL;
                    end else if (avg[RATIO_W-1]) begin
                        res_val_reg <= 9'd500;
                    end
                    m_reg <= avg[15:0];
                    e_reg <= '0;
                end
                ST_NORM: begin
                    if (!m_reg[15]) begin
                        m_reg <= {m_reg[14:0], 1'b0};
                        e_reg <= e_reg + 1'b1;
                    end else begin
                        kcnt_reg <= '0;
                        fr_reg   <= '0;
                    end
                end
                ST_LOGSQ: begin
                    if (mul_done) begin
                        m_reg    <= m_new;
                        fr_reg   <= fr_new;
                        kcnt_reg <= kcnt_reg + 1'b1;
                    end
                end
                ST_PMUL: begin
                    if (mul_done) begin
                        f_reg    <= mul_prod[29:14];
                        ip_reg   <= mul_prod[34:30];
                        r_reg    <= 33'h1_0000_0000;
                        ecnt_reg <= '0;
                    end
                end
                ST_EXPK: begin
                    if (!ecnt_reg[4]) begin
                        f_reg    <= {f_reg[14:0], 1'b0};
                        ecnt_reg <= ecnt_reg + 1'b1;
                    end
                end
                ST_EXPMUL: begin
                    if (mul_done) r_reg <= mul_prod[64:32];
                end
                ST_FMUL: begin
                    if (mul_done) res_val_reg <= mul_prod[40:32];
                end
                default: ;
            endcase
        end
    end

    dpsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    dpsp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_val_reg;
    assign m_axis_tdata  = {4'b0000, m_stat_reg, m_pedal_reg};

    assign mul_st = state_reg == ST_LOGSQ || state_reg == ST_PMUL
                 || state_reg == ST_EXPMUL || state_reg == ST_FMUL;
    assign div_st = state_reg == ST_DIV1 || state_reg == ST_DIV2;

    `DPSP_ASSERT_NEXT(a_latch_hold, latched_reg != STAT_OK, latched_reg == $past(latched_reg))
    `DPSP_ASSERT_IMPL(a_fault_zero, m_val_reg && m_stat_reg != STAT_OK, m_pedal_reg == 9'd0)
    `DPSP_ASSERT_IMPL(a_pedal_max, m_val_reg, m_pedal_reg <= 9'd500)
    `DPSP_ASSERT_IMPL(a_mul_owner, mul_done, mul_st)
    `DPSP_ASSERT_IMPL(a_div_owner, div_done, div_st)

endmodule

// ===== sv/dpsp_div.sv =====
// Bit-serial restoring divider: (num << 16) / den, one quotient bit per cycle.
// Depends on dpsp_pkg.
`timescale 1ns / 1ps

module dpsp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dpsp_pkg::SENS_W-1:0]   num,
    input  logic [dpsp_pkg::SENS_W-1:0]   den,
    output logic                          done,
    output logic [dpsp_pkg::RATIO_W-1:0]  quo
);
    import dpsp_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [SENS_W-1:0]   rem_reg;
    logic [SENS_W-1:0]   den_reg;
    logic [RATIO_W-1:0]  quo_reg;
    logic [SENS_W:0]     trial;
    logic                ge;
    logic [SENS_W-1:0]   rem_next;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? SENS_W'(trial - {1'b0, den_reg}) : trial[SENS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= {num, FRAC_W'(0)};
                rem_reg  <= '0;
                den_reg  <= den;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[RATIO_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/dpsp_mul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle, full-width product.
// Depends on dpsp_pkg.
`timescale 1ns / 1ps

module dpsp_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dpsp_pkg::MUL_A_W-1:0]  a,
    input  logic [dpsp_pkg::MUL_B_W-1:0]  b,
    output logic                          done,
    output logic [dpsp_pkg::MUL_P_W-1:0]  prod
);
    import dpsp_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MUL_A_W-1:0]  a_reg;
    logic [MUL_P_W-1:0]  acc_reg;
    logic [MUL_A_W:0]    sum;

    assign sum = {1'b0, acc_reg[MUL_P_W-1:MUL_B_W]}
               + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= a;
                acc_reg  <= {MUL_A_W'(0), b};
            end else if (busy_reg) begin
                acc_reg <= {sum, acc_reg[MUL_B_W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
